/* design/top_k_score_tracker_top_assert.svh */
// ----------------------------------------------------------------------------
// Top-K score tracker assertion macros
// Shorthand for the concurrent checks at the end of the tracker engine.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SCORE_TRACKER_TOP_ASSERT_SVH
`define TOP_K_SCORE_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define TKST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tkst assertion failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define TKST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkst assertion failed");

`endif

/* design/tkst_pkg.sv */
// ----------------------------------------------------------------------------
// Top-K score tracker package
// Item types, operation and status codes, and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package tkst_pkg;

    localparam int MAX_KEEP_DEFAULT = 16;
    localparam int SCORE_BITS       = 32;
    localparam int INDEX_BITS       = 32;
    localparam int LIMIT_BITS       = 5;
    localparam int FILL_BITS        = 5;
    localparam int RANK_BITS        = 4;
    localparam int STATUS_BITS      = 3;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [STATUS_BITS-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STATUS_BITS-1:0] STAT_DROPPED  = 3'd1;
    localparam logic [STATUS_BITS-1:0] STAT_READ_OK  = 3'd2;
    localparam logic [STATUS_BITS-1:0] STAT_BAD_RANK = 3'd3;
    localparam logic [STATUS_BITS-1:0] STAT_CLEARED  = 3'd4;

    typedef struct packed {
        logic [1:0]                   func;
        logic signed [SCORE_BITS-1:0] score;
        logic [INDEX_BITS-1:0]        point_index;
        logic [RANK_BITS-1:0]         rank;
    } tkst_req_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]       status;
        logic signed [SCORE_BITS-1:0] out_score;
        logic [INDEX_BITS-1:0]        out_index;
        logic [FILL_BITS-1:0]         fill_count;
    } tkst_rsp_t;

    typedef struct packed {
        logic      valid;
        tkst_rsp_t item;
    } tkst_res_t;

endpackage

`default_nettype wire

/* design/tkst_engine.sv */
// ----------------------------------------------------------------------------
// Top-K score tracker engine
// Sorted store in a memory, walked one entry per cycle by a small sequencer
// that compares stored scores with the new score for insertion and eviction.
// ----------------------------------------------------------------------------
`default_nettype none

module tkst_engine #(
    parameter int MAX_KEEP = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire tkst_pkg::tkst_req_t            req,
    input  wire logic [tkst_pkg::LIMIT_BITS-1:0] keep_limit,
    input  wire logic                           res_take,
    output logic                                idle,
    output tkst_pkg::tkst_res_t                 res
);
    import tkst_pkg::*;
    `include "top_k_score_tracker_top_assert.svh"

    localparam int CNT_W = $clog2(MAX_KEEP + 1);
    localparam int CW    = (CNT_W > LIMIT_BITS) ? CNT_W : LIMIT_BITS;
    localparam int AW    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_DN,
        S_FULL_CHK,
        S_INS_UP,
        S_PUT,
        S_READ,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    tkst_req_t               item_reg, item_next;
    logic [CW-1:0]           pos_reg, pos_next;
    logic [CW-1:0]           held_reg, held_next;
    logic                    grow_reg, grow_next;
    logic [STATUS_BITS-1:0]  status_reg, status_next;
    logic signed [SCORE_BITS-1:0] res_score_reg, res_score_next;
    logic [INDEX_BITS-1:0]   res_index_reg, res_index_next;

    logic signed [SCORE_BITS-1:0] score_mem [MAX_KEEP];
    logic [INDEX_BITS-1:0]        index_mem [MAX_KEEP];
    logic signed [SCORE_BITS-1:0] rd_score_reg;
    logic [INDEX_BITS-1:0]        rd_index_reg;

    logic                    we;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           raddr;
    logic signed [SCORE_BITS-1:0] wscore;
    logic [INDEX_BITS-1:0]   windex;

    logic [CW-1:0]           lim;
    logic [CW-1:0]           rank_ext;
    logic                    rd_le_new;
    logic                    rd_lt_new;

    always_comb
    begin
        if (keep_limit == '0)
        begin
            lim = CW'(1);
        end
        else if (CW'(keep_limit) > CW'(MAX_KEEP))
        begin
            lim = CW'(MAX_KEEP);
        end
        else
        begin
            lim = CW'(keep_limit);
        end
    end

    assign rank_ext  = CW'(req.rank);
    assign rd_le_new = (rd_score_reg <= item_reg.score);
    assign rd_lt_new = (rd_score_reg < item_reg.score);

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        pos_next       = pos_reg;
        held_next      = held_reg;
        grow_next      = grow_reg;
        status_next    = status_reg;
        res_score_next = res_score_reg;
        res_index_next = res_index_reg;
        we             = 1'b0;
        waddr          = pos_reg[AW-1:0];
        raddr          = '0;
        wscore         = item_reg.score;
        windex         = item_reg.point_index;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next      = req;
                    res_score_next = '0;
                    res_index_next = '0;
                    grow_next      = (held_reg < lim);
                    status_next    = STAT_DROPPED;
                    state_next     = S_DONE;
                    case (req.func)
                        FUNC_INSERT:
                        begin
                            if (held_reg < lim)
                            begin
                                if (held_reg == '0)
                                begin
                                    we          = 1'b1;
                                    waddr       = '0;
                                    wscore      = req.score;
                                    windex      = req.point_index;
                                    held_next   = CW'(1);
                                    status_next = STAT_INSERTED;
                                end
                                else
                                begin
                                    pos_next   = held_reg;
                                    raddr      = AW'(held_reg - CW'(1));
                                    state_next = S_INS_DN;
                                end
                            end
                            else
                            begin
                                raddr      = '0;
                                state_next = S_FULL_CHK;
                            end
                        end
                        FUNC_READ:
                        begin
                            if (rank_ext < held_reg)
                            begin
                                raddr      = AW'(held_reg - CW'(1) - rank_ext);
                                state_next = S_READ;
                            end
                            else
                            begin
                                status_next = STAT_BAD_RANK;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            held_next   = '0;
                            status_next = STAT_CLEARED;
                        end
                        default:
                        begin
                            status_next = STAT_DROPPED;
                        end
                    endcase
                end
            end
            S_INS_DN:
            begin
                we = 1'b1;
                if (!rd_le_new)
                begin
                    wscore   = rd_score_reg;
                    windex   = rd_index_reg;
                    pos_next = pos_reg - CW'(1);
                    if (pos_reg == CW'(1))
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        raddr = AW'(pos_reg - CW'(2));
                    end
                end
                else
                begin
                    held_next   = held_reg + CW'(1);
                    status_next = STAT_INSERTED;
                    state_next  = S_DONE;
                end
            end
            S_FULL_CHK:
            begin
                if (!rd_lt_new)
                begin
                    status_next = STAT_DROPPED;
                    state_next  = S_DONE;
                end
                else if (held_reg == CW'(1))
                begin
                    we          = 1'b1;
                    waddr       = '0;
                    status_next = STAT_INSERTED;
                    state_next  = S_DONE;
                end
                else
                begin
                    pos_next   = '0;
                    raddr      = AW'(1);
                    state_next = S_INS_UP;
                end
            end
            S_INS_UP:
            begin
                we = 1'b1;
                if (rd_le_new)
                begin
                    wscore   = rd_score_reg;
                    windex   = rd_index_reg;
                    pos_next = pos_reg + CW'(1);
                    if (pos_reg + CW'(2) == held_reg)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        raddr = AW'(pos_reg + CW'(2));
                    end
                end
                else
                begin
                    status_next = STAT_INSERTED;
                    state_next  = S_DONE;
                end
            end
            S_PUT:
            begin
                we          = 1'b1;
                status_next = STAT_INSERTED;
                state_next  = S_DONE;
                if (grow_reg)
                begin
                    held_next = held_reg + CW'(1);
                end
            end
            S_READ:
            begin
                res_score_next = rd_score_reg;
                res_index_next = rd_index_reg;
                status_next    = STAT_READ_OK;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        pos_reg       <= pos_next;
        grow_reg      <= grow_next;
        status_reg    <= status_next;
        res_score_reg <= res_score_next;
        res_index_reg <= res_index_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            score_mem[waddr] <= wscore;
            index_mem[waddr] <= windex;
        end
        rd_score_reg <= score_mem[raddr];
        rd_index_reg <= index_mem[raddr];
    end

    assign idle                = (state_reg == S_IDLE);
    assign res.valid           = (state_reg == S_DONE);
    assign res.item.status     = status_reg;
    assign res.item.out_score  = res_score_reg;
    assign res.item.out_index  = res_index_reg;
    assign res.item.fill_count = FILL_BITS'(held_reg);

    `TKST_ASSERT_IMP(a_held_max, 1'b1, held_reg <= CW'(MAX_KEEP))
    `TKST_ASSERT_IMP(a_held_step, held_reg != $past(held_reg), held_reg == $past(held_reg) + CW'(1) || held_reg == '0)
    `TKST_ASSERT_IMP(a_walk_up_bound, state_reg == S_INS_UP, pos_reg + CW'(1) < held_reg)
    `TKST_ASSERT_NXT(a_done_hold, state_reg == S_DONE && !res_take, state_reg == S_DONE)

endmodule

`default_nettype wire

/* design/top_k_score_tracker_top.sv */
// ----------------------------------------------------------------------------
// Top-K score tracker
// Keeps the highest (score, point index) pairs of a stream, sorted in a store.
// ----------------------------------------------------------------------------
// The req channel carries one item per operation: insert a pair, read the
// entry of a given rank (zero is the maximum), or clear the store. Each item
// gives exactly one rsp item with a status, the entry read and the fill count.
// Both channels use valid and ready; cfg_we writes the keep limit at once.
// An insert walks the sorted store one entry per cycle through the memory's
// read and write ports, comparing stored scores against the new score.
// One item is worked on at a time: req_ready is high only while the engine
// is idle. The response waits in an output register, so the engine finishes
// and frees up as soon as that register is empty or being taken; when the
// receiver stalls with a response pending, the next result waits in the
// engine and no further item is accepted.
// Reset empties the store (fill count zero) and sets the keep limit to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_score_tracker_top #(
    parameter int MAX_KEEP = tkst_pkg::MAX_KEEP_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire tkst_pkg::tkst_req_t             req,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output tkst_pkg::tkst_rsp_t                  rsp,
    input  wire logic                            cfg_we,
    input  wire logic [tkst_pkg::LIMIT_BITS-1:0] cfg_wdata
);
    import tkst_pkg::*;

    logic [LIMIT_BITS-1:0] keep_limit_reg;
    logic                  rsp_valid_reg;
    tkst_rsp_t             rsp_reg;
    logic                  eng_idle;
    tkst_res_t             eng_res;
    logic                  res_take;
    logic                  start;

    assign req_ready = eng_idle;
    assign start     = req_valid && eng_idle;
    assign res_take  = eng_res.valid && (!rsp_valid_reg || rsp_ready);

    tkst_engine #(
        .MAX_KEEP (MAX_KEEP)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (req),
        .keep_limit (keep_limit_reg),
        .res_take   (res_take),
        .idle       (eng_idle),
        .res        (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_limit_reg <= LIMIT_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                keep_limit_reg <= cfg_wdata;
            end
            if (res_take)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= eng_res.item;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* tb/top_k_score_tracker_top_test.sv */
// ----------------------------------------------------------------------------
// Top-K score tracker testbench
// Sends insert, read, clear and unused operations through the request channel.
// It predicts each response from its own sorted copy of the store and keep
// limit, and compares every response field by field against that prediction.
// Both channels idle and stall at random, and the keep limit is swept across
// a spread of values, including zero and values above the store depth.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_score_tracker_top_test;

    import tkst_pkg::*;

    localparam int MAX_KEEP    = MAX_KEEP_DEFAULT;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = 3 * (MAX_KEEP + 3);

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = 32'sh8000_0000;
    localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = 32'sh7FFF_FFFF;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    tkst_req_t             req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    tkst_rsp_t             rsp;
    logic                  cfg_we    = 1'b0;
    logic [LIMIT_BITS-1:0] cfg_wdata = '0;

    logic signed [SCORE_BITS-1:0] kept_score [MAX_KEEP];
    logic [INDEX_BITS-1:0]        kept_index [MAX_KEEP];
    int                           held = 0;
    logic [LIMIT_BITS-1:0]        keep_limit_q = LIMIT_RESET;

    tkst_rsp_t due_rsp[$];
    int        mismatches   = 0;
    int        quiet_cycles = 0;
    int        stall_left   = 0;
    bit        steady       = 1'b0;

    top_k_score_tracker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    function automatic tkst_rsp_t top_k_update(tkst_req_t item);
        tkst_rsp_t                    res;
        logic signed [SCORE_BITS-1:0] s;
        int                           lim;
        int                           slot;
        int                           i;
        res = '0;
        res.status = STAT_DROPPED;
        s = item.score;
        if (keep_limit_q == 0)
            lim = 1;
        else if (keep_limit_q > MAX_KEEP)
            lim = MAX_KEEP;
        else
            lim = int'(keep_limit_q);
        case (item.func)
            FUNC_INSERT:
            begin
                slot = 0;
                while (slot < held && kept_score[slot] <= s)
                    slot++;
                if (held < lim)
                begin
                    for (i = held; i > slot; i--)
                    begin
                        kept_score[i] = kept_score[i-1];
                        kept_index[i] = kept_index[i-1];
                    end
                    kept_score[slot] = s;
                    kept_index[slot] = item.point_index;
                    held++;
                    res.status = STAT_INSERTED;
                end
                else if (held > 0 && s > kept_score[0])
                begin
                    for (i = 0; i + 1 < slot; i++)
                    begin
                        kept_score[i] = kept_score[i+1];
                        kept_index[i] = kept_index[i+1];
                    end
                    kept_score[slot-1] = s;
                    kept_index[slot-1] = item.point_index;
                    res.status = STAT_INSERTED;
                end
            end
            FUNC_READ:
            begin
                if (item.rank < held)
                begin
                    res.out_score = kept_score[held-1-item.rank];
                    res.out_index = kept_index[held-1-item.rank];
                    res.status    = STAT_READ_OK;
                end
                else
                    res.status = STAT_BAD_RANK;
            end
            FUNC_CLEAR:
            begin
                held = 0;
                res.status = STAT_CLEARED;
            end
            default: ;
        endcase
        res.fill_count = FILL_BITS'(held);
        return res;
    endfunction

    function automatic tkst_req_t make_req(logic [1:0] func, logic signed [SCORE_BITS-1:0] s,
                                           logic [INDEX_BITS-1:0] idx, logic [RANK_BITS-1:0] r);
        tkst_req_t item;
        item.func        = func;
        item.score       = s;
        item.point_index = idx;
        item.rank        = r;
        return item;
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SCORE_BITS-1:0] pick_score();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return $urandom;
        if (roll < 70)
            return $urandom_range(0, 7) - 4;
        if (roll < 85)
        begin
            case ($urandom_range(0, 3))
                0: return SCORE_MIN;
                1: return SCORE_MAX;
                2: return 0;
                default: return -1;
            endcase
        end
        if (held > 0)
            return kept_score[0] + $urandom_range(0, 2) - 1;
        return $urandom;
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!steady && $urandom_range(0, 99) < 20)
        begin
            rsp_ready <= 1'b0;
            stall_left <= idle_len() - 1;
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        tkst_rsp_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
                due_rsp.insert(due_rsp.size(), top_k_update(req));
            if (rsp_valid && rsp_ready)
            begin
                if (due_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response: status %0d score %0d index %h fill %0d",
                                 rsp.status, rsp.out_score, rsp.out_index, rsp.fill_count);
                end
                else
                begin
                    want = due_rsp.pop_front();
                    if (rsp.status !== want.status || rsp.out_score !== want.out_score ||
                        rsp.out_index !== want.out_index || rsp.fill_count !== want.fill_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("response mismatch (expected/actual): status %0d/%0d",
                                     want.status, rsp.status);
                            $display("  score %0d/%0d index %h/%h fill %0d/%0d",
                                     want.out_score, rsp.out_score,
                                     want.out_index, rsp.out_index,
                                     want.fill_count, rsp.fill_count);
                        end
                    end
                end
            end
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    task automatic send_item(tkst_req_t item);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) >= 50)
            gap = idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic wait_for_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (due_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_keep_limit(logic [LIMIT_BITS-1:0] value);
        wait_for_responses();
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        keep_limit_q = value;
    endtask

    task automatic test_empty_and_extremes();
        send_item(make_req(FUNC_READ, 0, 0, 0));
        send_item(make_req(FUNC_UNUSED, SCORE_MAX, '1, '1));
        send_item(make_req(FUNC_INSERT, SCORE_MIN, 0, 0));
        send_item(make_req(FUNC_INSERT, SCORE_MAX, 32'hFFFF_FFFF, 4'hF));
        send_item(make_req(FUNC_INSERT, 0, 5, 0));
        send_item(make_req(FUNC_INSERT, 0, 6, 0));
        send_item(make_req(FUNC_READ, 0, 0, 0));
        send_item(make_req(FUNC_READ, 0, 0, 1));
        send_item(make_req(FUNC_READ, 0, 0, 2));
        send_item(make_req(FUNC_READ, 0, 0, 3));
        send_item(make_req(FUNC_READ, 0, 0, 4'hF));
        send_item(make_req(FUNC_CLEAR, 0, 0, 0));
        send_item(make_req(FUNC_READ, 0, 0, 0));
    endtask

    task automatic test_limit_corners();
        // A limit of zero behaves as one, and an equal score never evicts.
        set_keep_limit(0);
        send_item(make_req(FUNC_INSERT, 10, 1, 0));
        send_item(make_req(FUNC_INSERT, 10, 2, 0));
        send_item(make_req(FUNC_INSERT, 11, 3, 0));
        send_item(make_req(FUNC_READ, 0, 0, 0));
        set_keep_limit(31);
        send_item(make_req(FUNC_INSERT, 20, 4, 0));
        send_item(make_req(FUNC_INSERT, 5, 5, 0));
        // Lowering the limit below the fill keeps every entry.
        set_keep_limit(2);
        send_item(make_req(FUNC_INSERT, 4, 6, 0));
        send_item(make_req(FUNC_INSERT, 30, 7, 0));
        send_item(make_req(FUNC_READ, 0, 0, 2));
    endtask

    task automatic test_random_stream(int count, logic [LIMIT_BITS-1:0] limit, bit calm);
        tkst_req_t item;
        int        roll;
        set_keep_limit(limit);
        steady = calm;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                item.func = FUNC_INSERT;
            else if (roll < 96)
                item.func = FUNC_READ;
            else if (roll < 98)
                item.func = FUNC_CLEAR;
            else
                item.func = FUNC_UNUSED;
            item.score       = pick_score();
            item.point_index = $urandom;
            item.rank        = RANK_BITS'($urandom_range(0, 15));
            send_item(item);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        logic [LIMIT_BITS-1:0] phase_limits [11];
        logic [LIMIT_BITS-1:0] limit;
        phase_limits = '{5'd16, 5'd1, 5'd7, 5'd31, 5'd0, 5'd2, 5'd17, 5'd16, 5'd9, 5'd24,
                         5'd12};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_extremes();
        test_limit_corners();
        for (int p = 0; p < 11; p++)
        begin
            limit = (p == 8) ? LIMIT_BITS'($urandom_range(0, 31)) : phase_limits[p];
            test_random_stream(95, limit, p == 7);
        end
        wait_for_responses();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
